// ----- hdl/circle_pair_collision_resolve_defines.svh -----
// Assertion macros for the circle pair collision resolver.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef CIRCLE_PAIR_COLLISION_RESOLVE_DEFINES_SVH
`define CIRCLE_PAIR_COLLISION_RESOLVE_DEFINES_SVH
`ifndef ASSERT_OFF
`define CPCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CPCR_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CPCR_ASSERT(lbl, prop, msg)
`define CPCR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- hdl/cpcr_pkg.sv -----
// Shared types, widths, status codes and rounding helpers for the
// circle pair collision resolver. No dependencies.
package cpcr_pkg;

    localparam int VAL_W   = 24;
    localparam int RADI_W  = 20;
    localparam int REST_W  = 17;
    localparam int DIFF_W  = 25;
    localparam int MIND_W  = 21;
    localparam int SQ_W    = 50;
    localparam int RAD_W   = 42;
    localparam int DIST_W  = 21;
    localparam int NORM_BITS = 16;
    localparam int NUM_W   = 38;
    localparam int Q_W     = 17;
    localparam int NRM_W   = 18;
    localparam int OVL_W   = 22;
    localparam int PC_W    = 40;
    localparam int PV_W    = 43;
    localparam int VN_W    = 44;
    localparam int K_W     = 18;
    localparam int PK_W    = 62;
    localparam int IMP_W   = 30;
    localparam int PI_W    = 49;
    localparam int WIDE_W  = 48;
    localparam int CX_W    = 22;
    localparam int STAT_W  = 2;

    localparam int SQRT_STAGES = 21;
    localparam int DIV_STAGES  = 17;
    localparam int X1_IDX      = 3 + SQRT_STAGES + DIV_STAGES;
    localparam int PIPE_DEPTH  = X1_IDX + 7;

    localparam logic [REST_W-1:0] REST_RESET = 17'd52429;
    localparam logic [REST_W-1:0] REST_ONE   = 17'd65536;
    localparam logic signed [NRM_W-1:0] NRM_ONE = 18'sd65536;

    localparam logic signed [WIDE_W-1:0] MAX24 = 48'sd8388607;
    localparam logic signed [WIDE_W-1:0] MIN24 = -48'sd8388608;

    localparam logic [STAT_W-1:0] ST_NONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_SEP     = 2'd1;
    localparam logic [STAT_W-1:0] ST_IMPULSE = 2'd2;
    localparam logic [STAT_W-1:0] ST_COINC   = 2'd3;

    typedef struct packed {
        logic signed [VAL_W-1:0] pos_a_x;
        logic signed [VAL_W-1:0] pos_a_y;
        logic signed [VAL_W-1:0] pos_b_x;
        logic signed [VAL_W-1:0] pos_b_y;
        logic signed [VAL_W-1:0] vel_a_x;
        logic signed [VAL_W-1:0] vel_a_y;
        logic signed [VAL_W-1:0] vel_b_x;
        logic signed [VAL_W-1:0] vel_b_y;
        logic [RADI_W-1:0]       radius_a;
        logic [RADI_W-1:0]       radius_b;
    } pair_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] new_pos_a_x;
        logic signed [VAL_W-1:0] new_pos_a_y;
        logic signed [VAL_W-1:0] new_pos_b_x;
        logic signed [VAL_W-1:0] new_pos_b_y;
        logic signed [VAL_W-1:0] new_vel_a_x;
        logic signed [VAL_W-1:0] new_vel_a_y;
        logic signed [VAL_W-1:0] new_vel_b_x;
        logic signed [VAL_W-1:0] new_vel_b_y;
        logic [STAT_W-1:0]       contact_status;
    } result_t;

    // Request fields carried alongside the square root and divider
    typedef struct packed {
        pair_t              item;
        logic [MIND_W-1:0]  mind;
        logic               contact;
        logic               coinc;
        logic               sx;
        logic               sy;
        logic [DIST_W-1:0]  adx;
        logic [DIST_W-1:0]  ady;
    } side_t;

    function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                     input int unsigned s);
        logic signed [63:0] half;
        half = 64'sd1 <<< (s - 1);
        if (v >= 0)
            return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic logic signed [VAL_W-1:0] sat24(input logic signed [WIDE_W-1:0] v);
        if (v > MAX24)
            return MAX24[VAL_W-1:0];
        if (v < MIN24)
            return MIN24[VAL_W-1:0];
        return v[VAL_W-1:0];
    endfunction

endpackage

// ----- hdl/cpcr_pair_if.sv -----
// Input channel for circle pairs: valid/ready plus one pair request.
// Depends on cpcr_pkg.
interface cpcr_pair_if;
    logic            valid;
    logic            ready;
    cpcr_pkg::pair_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/cpcr_result_if.sv -----
// Output channel for resolved pairs: valid/ready plus one result.
// Depends on cpcr_pkg.
interface cpcr_result_if;
    logic              valid;
    logic              ready;
    cpcr_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/cpcr_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on cpcr_pkg for widths and stage count.
module cpcr_sqrt (
    input  logic                            clk,
    input  logic                            en,
    input  logic [cpcr_pkg::RAD_W-1:0]      rad,
    output logic [cpcr_pkg::DIST_W-1:0]     root
);

    localparam int N = cpcr_pkg::SQRT_STAGES;
    localparam int W = cpcr_pkg::RAD_W;

    logic [W-1:0] rem_reg  [0:N-1];
    logic [W-1:0] res_reg  [0:N-1];
    logic [W-1:0] rem_next [0:N-1];
    logic [W-1:0] res_next [0:N-1];
    logic [W-1:0] rem_in   [0:N-1];
    logic [W-1:0] res_in   [0:N-1];
    logic [W-1:0] bitv     [0:N-1];
    logic [W-1:0] trial    [0:N-1];

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            rem_in[i] = (i == 0) ? rad : rem_reg[(i == 0) ? 0 : i - 1];
            res_in[i] = (i == 0) ? '0  : res_reg[(i == 0) ? 0 : i - 1];
            bitv[i]   = W'(1) << (W - 2 - 2 * i);
            trial[i]  = res_in[i] + bitv[i];
            if (rem_in[i] >= trial[i])
            begin
                rem_next[i] = rem_in[i] - trial[i];
                res_next[i] = (res_in[i] >> 1) + bitv[i];
            end
            else
            begin
                rem_next[i] = rem_in[i];
                res_next[i] = res_in[i] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                rem_reg[i] <= rem_next[i];
                res_reg[i] <= res_next[i];
            end
        end
    end

    assign root = res_reg[N-1][cpcr_pkg::DIST_W-1:0];

endmodule

// ----- hdl/cpcr_div.sv -----
// Pipelined restoring divider, one quotient bit per stage; the divisor
// travels with the data. Depends on cpcr_pkg for widths and stage count.
module cpcr_div (
    input  logic                            clk,
    input  logic                            en,
    input  logic [cpcr_pkg::NUM_W-1:0]      num,
    input  logic [cpcr_pkg::DIST_W-1:0]     den,
    output logic [cpcr_pkg::Q_W-1:0]        quo,
    output logic [cpcr_pkg::DIST_W-1:0]     den_out
);

    localparam int N  = cpcr_pkg::DIV_STAGES;
    localparam int NW = cpcr_pkg::NUM_W;
    localparam int DW = cpcr_pkg::DIST_W;
    localparam int QW = cpcr_pkg::Q_W;

    logic [NW-1:0] rem_reg  [0:N-1];
    logic [QW-1:0] q_reg    [0:N-1];
    logic [DW-1:0] den_reg  [0:N-1];
    logic [NW-1:0] rem_next [0:N-1];
    logic [QW-1:0] q_next   [0:N-1];
    logic [NW-1:0] rem_in   [0:N-1];
    logic [QW-1:0] q_in     [0:N-1];
    logic [DW-1:0] den_in   [0:N-1];
    logic [NW:0]   trial    [0:N-1];

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            rem_in[i] = (i == 0) ? num : rem_reg[(i == 0) ? 0 : i - 1];
            q_in[i]   = (i == 0) ? '0  : q_reg[(i == 0) ? 0 : i - 1];
            den_in[i] = (i == 0) ? den : den_reg[(i == 0) ? 0 : i - 1];
            trial[i]  = {1'b0, rem_in[i]} - ((NW + 1)'(den_in[i]) << (QW - 1 - i));
            if (!trial[i][NW])
            begin
                rem_next[i] = trial[i][NW-1:0];
                q_next[i]   = {q_in[i][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = rem_in[i];
                q_next[i]   = {q_in[i][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                rem_reg[i] <= rem_next[i];
                q_reg[i]   <= q_next[i];
                den_reg[i] <= den_in[i];
            end
        end
    end

    assign quo     = q_reg[N-1];
    assign den_out = den_reg[N-1];

endmodule

// ----- hdl/circle_pair_collision_resolve.sv -----
// Equal-mass circle pair collision resolver, fully pipelined.
// Throughput is one pair per cycle while the skid stage is free; pair.ready drops while it holds a result.
// Depth is set by the 21-stage square root and the 17-stage normal divider.
// A two-entry output register and skid stage decouple the result side from the pipeline.
// Reset (rst_n low, asynchronous) clears all valid bits and loads restitution 52429.
// Depends on cpcr_pkg, cpcr_pair_if, cpcr_result_if, cpcr_sqrt, cpcr_div.
`include "circle_pair_collision_resolve_defines.svh"

module circle_pair_collision_resolve (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cpcr_pkg::REST_W-1:0]     cfg_wdata,
    cpcr_pair_if.sink                       pair,
    cpcr_result_if.source                   result
);

    typedef struct packed {
        cpcr_pkg::pair_t                        item;
        logic signed [cpcr_pkg::DIFF_W-1:0]     dx;
        logic signed [cpcr_pkg::DIFF_W-1:0]     dy;
        logic [cpcr_pkg::MIND_W-1:0]            mind;
    } s1_t;

    typedef struct packed {
        cpcr_pkg::pair_t                        item;
        logic signed [cpcr_pkg::DIFF_W-1:0]     dx;
        logic signed [cpcr_pkg::DIFF_W-1:0]     dy;
        logic [cpcr_pkg::MIND_W-1:0]            mind;
        logic [cpcr_pkg::SQ_W-1:0]              dx2;
        logic [cpcr_pkg::SQ_W-1:0]              dy2;
        logic [cpcr_pkg::RAD_W-1:0]             msq;
    } s2_t;

    typedef struct packed {
        cpcr_pkg::pair_t                        item;
        logic                                   contact;
        logic                                   coinc;
        logic signed [cpcr_pkg::NRM_W-1:0]      nx;
        logic signed [cpcr_pkg::NRM_W-1:0]      ny;
        logic signed [cpcr_pkg::OVL_W-1:0]      ovl;
        logic signed [cpcr_pkg::DIFF_W-1:0]     dvx;
        logic signed [cpcr_pkg::DIFF_W-1:0]     dvy;
    } x1_t;

    typedef struct packed {
        cpcr_pkg::pair_t                        item;
        logic                                   contact;
        logic                                   coinc;
        logic signed [cpcr_pkg::NRM_W-1:0]      nx;
        logic signed [cpcr_pkg::NRM_W-1:0]      ny;
        logic signed [cpcr_pkg::PC_W-1:0]       pcx;
        logic signed [cpcr_pkg::PC_W-1:0]       pcy;
        logic signed [cpcr_pkg::PV_W-1:0]       pvx;
        logic signed [cpcr_pkg::PV_W-1:0]       pvy;
    } x2_t;

    typedef struct packed {
        logic signed [cpcr_pkg::VAL_W-1:0]      pax;
        logic signed [cpcr_pkg::VAL_W-1:0]      pay;
        logic signed [cpcr_pkg::VAL_W-1:0]      pbx;
        logic signed [cpcr_pkg::VAL_W-1:0]      pby;
    } cpos_t;

    typedef struct packed {
        cpcr_pkg::pair_t                        item;
        logic                                   contact;
        logic                                   coinc;
        logic                                   sep;
        logic signed [cpcr_pkg::NRM_W-1:0]      nx;
        logic signed [cpcr_pkg::NRM_W-1:0]      ny;
        cpos_t                                  cpos;
        logic [cpcr_pkg::VN_W-1:0]              negvn;
    } x3_t;

    typedef struct packed {
        cpcr_pkg::pair_t                        item;
        logic                                   contact;
        logic                                   coinc;
        logic                                   sep;
        logic signed [cpcr_pkg::NRM_W-1:0]      nx;
        logic signed [cpcr_pkg::NRM_W-1:0]      ny;
        cpos_t                                  cpos;
        logic [cpcr_pkg::PK_W-1:0]              prodk;
    } x4_t;

    typedef struct packed {
        cpcr_pkg::pair_t                        item;
        logic                                   contact;
        logic                                   coinc;
        logic                                   sep;
        logic signed [cpcr_pkg::NRM_W-1:0]      nx;
        logic signed [cpcr_pkg::NRM_W-1:0]      ny;
        cpos_t                                  cpos;
        logic [cpcr_pkg::IMP_W-1:0]             imp;
    } x5_t;

    typedef struct packed {
        cpcr_pkg::pair_t                        item;
        logic                                   contact;
        logic                                   coinc;
        logic                                   sep;
        cpos_t                                  cpos;
        logic signed [cpcr_pkg::PI_W-1:0]       pix;
        logic signed [cpcr_pkg::PI_W-1:0]       piy;
    } x6_t;

    localparam int NS = cpcr_pkg::SQRT_STAGES;
    localparam int ND = cpcr_pkg::DIV_STAGES;
    localparam int PD = cpcr_pkg::PIPE_DEPTH;

    logic                           en;
    logic [PD-1:0]                  pipe_vld_reg;
    logic [cpcr_pkg::REST_W-1:0]    restitution_reg;

    s1_t                            s1_reg, s1_next;
    s2_t                            s2_reg, s2_next;
    cpcr_pkg::side_t                s3_reg, s3_next;
    logic [cpcr_pkg::RAD_W-1:0]     s3_rad_reg, s3_rad_next;
    cpcr_pkg::side_t                side_a_reg [0:NS-1];
    cpcr_pkg::side_t                side_b_reg [0:ND-1];
    x1_t                            x1_reg, x1_next;
    x2_t                            x2_reg, x2_next;
    x3_t                            x3_reg, x3_next;
    x4_t                            x4_reg, x4_next;
    x5_t                            x5_reg, x5_next;
    x6_t                            x6_reg, x6_next;
    cpcr_pkg::result_t              x7_reg, x7_next;

    logic                           out_vld_reg, skid_vld_reg;
    cpcr_pkg::result_t              out_data_reg, skid_data_reg;

    logic [cpcr_pkg::DIST_W-1:0]    root;
    logic [cpcr_pkg::NUM_W-1:0]     num_x, num_y;
    logic [cpcr_pkg::Q_W-1:0]       quo_x, quo_y;
    logic [cpcr_pkg::DIST_W-1:0]    dist_x, dist_y;

    logic [cpcr_pkg::SQ_W-1:0]      d2;
    logic signed [cpcr_pkg::DIFF_W-1:0] adx_full, ady_full;
    logic signed [cpcr_pkg::SQ_W-1:0]   sqx, sqy;
    logic signed [cpcr_pkg::NRM_W-1:0]  qsx, qsy, nxr, nyr;
    logic signed [cpcr_pkg::CX_W-1:0]   cx, cy;
    logic signed [cpcr_pkg::VN_W-1:0]   vn;
    logic [cpcr_pkg::REST_W-1:0]        rest_eff;
    logic [cpcr_pkg::K_W-1:0]           kfac;
    logic signed [cpcr_pkg::WIDE_W-1:0] ix, iy;
    logic                               x1_active;

    // The pipeline moves whenever the skid stage is free
    assign en         = !skid_vld_reg;
    assign pair.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            restitution_reg <= cpcr_pkg::REST_RESET;
        else if (cfg_we)
            restitution_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pipe_vld_reg <= '0;
        else if (en)
            pipe_vld_reg <= {pipe_vld_reg[PD-2:0], pair.valid};
    end

    // Stage 1: centre difference and radius sum
    always_comb
    begin
        s1_next.item = pair.data;
        s1_next.dx   = cpcr_pkg::DIFF_W'(pair.data.pos_b_x) - cpcr_pkg::DIFF_W'(pair.data.pos_a_x);
        s1_next.dy   = cpcr_pkg::DIFF_W'(pair.data.pos_b_y) - cpcr_pkg::DIFF_W'(pair.data.pos_a_y);
        s1_next.mind = cpcr_pkg::MIND_W'(pair.data.radius_a)
                     + cpcr_pkg::MIND_W'(pair.data.radius_b);
    end

    // Stage 2: squares
    assign sqx = s1_reg.dx * s1_reg.dx;
    assign sqy = s1_reg.dy * s1_reg.dy;

    always_comb
    begin
        s2_next.item = s1_reg.item;
        s2_next.dx   = s1_reg.dx;
        s2_next.dy   = s1_reg.dy;
        s2_next.mind = s1_reg.mind;
        s2_next.dx2  = cpcr_pkg::SQ_W'(sqx);
        s2_next.dy2  = cpcr_pkg::SQ_W'(sqy);
        s2_next.msq  = cpcr_pkg::RAD_W'(s1_reg.mind) * cpcr_pkg::RAD_W'(s1_reg.mind);
    end

    // Stage 3: contact test; zero the root and divider inputs when there is no contact
    assign d2       = s2_reg.dx2 + s2_reg.dy2;
    assign adx_full = s2_reg.dx[cpcr_pkg::DIFF_W-1] ? -s2_reg.dx : s2_reg.dx;
    assign ady_full = s2_reg.dy[cpcr_pkg::DIFF_W-1] ? -s2_reg.dy : s2_reg.dy;

    always_comb
    begin
        s3_next.item    = s2_reg.item;
        s3_next.mind    = s2_reg.mind;
        s3_next.contact = d2 < cpcr_pkg::SQ_W'(s2_reg.msq);
        s3_next.coinc   = (d2 == '0);
        s3_next.sx      = s2_reg.dx[cpcr_pkg::DIFF_W-1];
        s3_next.sy      = s2_reg.dy[cpcr_pkg::DIFF_W-1];
        s3_next.adx     = s3_next.contact ? adx_full[cpcr_pkg::DIST_W-1:0] : '0;
        s3_next.ady     = s3_next.contact ? ady_full[cpcr_pkg::DIST_W-1:0] : '0;
        s3_rad_next     = s3_next.contact ? d2[cpcr_pkg::RAD_W-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
            s3_reg     <= s3_next;
            s3_rad_reg <= s3_rad_next;
            side_a_reg[0] <= s3_reg;
            for (int i = 1; i < NS; i++)
                side_a_reg[i] <= side_a_reg[i-1];
            side_b_reg[0] <= side_a_reg[NS-1];
            for (int i = 1; i < ND; i++)
                side_b_reg[i] <= side_b_reg[i-1];
            x1_reg <= x1_next;
            x2_reg <= x2_next;
            x3_reg <= x3_next;
            x4_reg <= x4_next;
            x5_reg <= x5_next;
            x6_reg <= x6_next;
            x7_reg <= x7_next;
        end
    end

    cpcr_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (s3_rad_reg),
        .root (root)
    );

    // Rounded quotient: (|d| * 2^16 + dist/2) / dist
    assign num_x = (cpcr_pkg::NUM_W'(side_a_reg[NS-1].adx) << cpcr_pkg::NORM_BITS)
                 + cpcr_pkg::NUM_W'(root >> 1);
    assign num_y = (cpcr_pkg::NUM_W'(side_a_reg[NS-1].ady) << cpcr_pkg::NORM_BITS)
                 + cpcr_pkg::NUM_W'(root >> 1);

    cpcr_div u_div_x (
        .clk     (clk),
        .en      (en),
        .num     (num_x),
        .den     (root),
        .quo     (quo_x),
        .den_out (dist_x)
    );

    cpcr_div u_div_y (
        .clk     (clk),
        .en      (en),
        .num     (num_y),
        .den     (root),
        .quo     (quo_y),
        .den_out (dist_y)
    );

    // X1: signed, clamped normal, overlap and relative velocity
    assign qsx = signed'({1'b0, quo_x});
    assign qsy = signed'({1'b0, quo_y});
    assign nxr = side_b_reg[ND-1].sx ? -qsx : qsx;
    assign nyr = side_b_reg[ND-1].sy ? -qsy : qsy;

    always_comb
    begin
        x1_next.item    = side_b_reg[ND-1].item;
        x1_next.contact = side_b_reg[ND-1].contact;
        x1_next.coinc   = side_b_reg[ND-1].coinc;
        x1_next.nx      = (nxr > cpcr_pkg::NRM_ONE) ? cpcr_pkg::NRM_ONE
                        : (nxr < -cpcr_pkg::NRM_ONE) ? -cpcr_pkg::NRM_ONE : nxr;
        x1_next.ny      = (nyr > cpcr_pkg::NRM_ONE) ? cpcr_pkg::NRM_ONE
                        : (nyr < -cpcr_pkg::NRM_ONE) ? -cpcr_pkg::NRM_ONE : nyr;
        x1_next.ovl     = signed'(cpcr_pkg::OVL_W'(side_b_reg[ND-1].mind))
                        - signed'(cpcr_pkg::OVL_W'(dist_x));
        x1_next.dvx     = cpcr_pkg::DIFF_W'(side_b_reg[ND-1].item.vel_b_x)
                        - cpcr_pkg::DIFF_W'(side_b_reg[ND-1].item.vel_a_x);
        x1_next.dvy     = cpcr_pkg::DIFF_W'(side_b_reg[ND-1].item.vel_b_y)
                        - cpcr_pkg::DIFF_W'(side_b_reg[ND-1].item.vel_a_y);
    end

    // X2: correction and closing-speed products
    always_comb
    begin
        x2_next.item    = x1_reg.item;
        x2_next.contact = x1_reg.contact;
        x2_next.coinc   = x1_reg.coinc;
        x2_next.nx      = x1_reg.nx;
        x2_next.ny      = x1_reg.ny;
        x2_next.pcx     = x1_reg.nx * x1_reg.ovl;
        x2_next.pcy     = x1_reg.ny * x1_reg.ovl;
        x2_next.pvx     = x1_reg.dvx * x1_reg.nx;
        x2_next.pvy     = x1_reg.dvy * x1_reg.ny;
    end

    // X3: push positions apart, sum the normal speed
    assign cx = cpcr_pkg::CX_W'(cpcr_pkg::shr_round(64'(x2_reg.pcx), cpcr_pkg::NORM_BITS + 1));
    assign cy = cpcr_pkg::CX_W'(cpcr_pkg::shr_round(64'(x2_reg.pcy), cpcr_pkg::NORM_BITS + 1));
    assign vn = cpcr_pkg::VN_W'(x2_reg.pvx) + cpcr_pkg::VN_W'(x2_reg.pvy);

    always_comb
    begin
        x3_next.item     = x2_reg.item;
        x3_next.contact  = x2_reg.contact;
        x3_next.coinc    = x2_reg.coinc;
        x3_next.sep      = vn > 0;
        x3_next.nx       = x2_reg.nx;
        x3_next.ny       = x2_reg.ny;
        x3_next.cpos.pax = cpcr_pkg::sat24(cpcr_pkg::WIDE_W'(x2_reg.item.pos_a_x)
                                           - cpcr_pkg::WIDE_W'(cx));
        x3_next.cpos.pay = cpcr_pkg::sat24(cpcr_pkg::WIDE_W'(x2_reg.item.pos_a_y)
                                           - cpcr_pkg::WIDE_W'(cy));
        x3_next.cpos.pbx = cpcr_pkg::sat24(cpcr_pkg::WIDE_W'(x2_reg.item.pos_b_x)
                                           + cpcr_pkg::WIDE_W'(cx));
        x3_next.cpos.pby = cpcr_pkg::sat24(cpcr_pkg::WIDE_W'(x2_reg.item.pos_b_y)
                                           + cpcr_pkg::WIDE_W'(cy));
        x3_next.negvn    = unsigned'(-vn);
    end

    // X4: scale closing speed by (1 + restitution)
    assign rest_eff = (restitution_reg > cpcr_pkg::REST_ONE) ? cpcr_pkg::REST_ONE
                                                             : restitution_reg;
    assign kfac     = cpcr_pkg::K_W'(cpcr_pkg::REST_ONE) + cpcr_pkg::K_W'(rest_eff);

    always_comb
    begin
        x4_next.item    = x3_reg.item;
        x4_next.contact = x3_reg.contact;
        x4_next.coinc   = x3_reg.coinc;
        x4_next.sep     = x3_reg.sep;
        x4_next.nx      = x3_reg.nx;
        x4_next.ny      = x3_reg.ny;
        x4_next.cpos    = x3_reg.cpos;
        x4_next.prodk   = cpcr_pkg::PK_W'(x3_reg.negvn) * cpcr_pkg::PK_W'(kfac);
    end

    // X5: impulse magnitude, product is non-negative on the impulse path
    always_comb
    begin
        x5_next.item    = x4_reg.item;
        x5_next.contact = x4_reg.contact;
        x5_next.coinc   = x4_reg.coinc;
        x5_next.sep     = x4_reg.sep;
        x5_next.nx      = x4_reg.nx;
        x5_next.ny      = x4_reg.ny;
        x5_next.cpos    = x4_reg.cpos;
        x5_next.imp     = cpcr_pkg::IMP_W'((x4_reg.prodk + (cpcr_pkg::PK_W'(1) << 32)) >> 33);
    end

    // X6: impulse vector products
    always_comb
    begin
        x6_next.item    = x5_reg.item;
        x6_next.contact = x5_reg.contact;
        x6_next.coinc   = x5_reg.coinc;
        x6_next.sep     = x5_reg.sep;
        x6_next.cpos    = x5_reg.cpos;
        x6_next.pix     = x5_reg.nx * signed'({1'b0, x5_reg.imp});
        x6_next.piy     = x5_reg.ny * signed'({1'b0, x5_reg.imp});
    end

    // X7: apply impulse and select outputs by case
    assign ix = cpcr_pkg::WIDE_W'(cpcr_pkg::shr_round(64'(x6_reg.pix), cpcr_pkg::NORM_BITS));
    assign iy = cpcr_pkg::WIDE_W'(cpcr_pkg::shr_round(64'(x6_reg.piy), cpcr_pkg::NORM_BITS));

    always_comb
    begin
        x7_next.new_pos_a_x = x6_reg.item.pos_a_x;
        x7_next.new_pos_a_y = x6_reg.item.pos_a_y;
        x7_next.new_pos_b_x = x6_reg.item.pos_b_x;
        x7_next.new_pos_b_y = x6_reg.item.pos_b_y;
        x7_next.new_vel_a_x = x6_reg.item.vel_a_x;
        x7_next.new_vel_a_y = x6_reg.item.vel_a_y;
        x7_next.new_vel_b_x = x6_reg.item.vel_b_x;
        x7_next.new_vel_b_y = x6_reg.item.vel_b_y;
        if (!x6_reg.contact)
            x7_next.contact_status = cpcr_pkg::ST_NONE;
        else if (x6_reg.coinc)
            x7_next.contact_status = cpcr_pkg::ST_COINC;
        else
        begin
            x7_next.new_pos_a_x = x6_reg.cpos.pax;
            x7_next.new_pos_a_y = x6_reg.cpos.pay;
            x7_next.new_pos_b_x = x6_reg.cpos.pbx;
            x7_next.new_pos_b_y = x6_reg.cpos.pby;
            if (x6_reg.sep)
                x7_next.contact_status = cpcr_pkg::ST_SEP;
            else
            begin
                x7_next.contact_status = cpcr_pkg::ST_IMPULSE;
                x7_next.new_vel_a_x = cpcr_pkg::sat24(
                    cpcr_pkg::WIDE_W'(x6_reg.item.vel_a_x) - ix);
                x7_next.new_vel_a_y = cpcr_pkg::sat24(
                    cpcr_pkg::WIDE_W'(x6_reg.item.vel_a_y) - iy);
                x7_next.new_vel_b_x = cpcr_pkg::sat24(
                    cpcr_pkg::WIDE_W'(x6_reg.item.vel_b_x) + ix);
                x7_next.new_vel_b_y = cpcr_pkg::sat24(
                    cpcr_pkg::WIDE_W'(x6_reg.item.vel_b_y) + iy);
            end
        end
    end

    // Output register with skid: catch the leaving request while the sink stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || result.ready)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
                out_vld_reg <= pipe_vld_reg[PD-1];
        end
        else if (!skid_vld_reg && pipe_vld_reg[PD-1])
            skid_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || result.ready)
            out_data_reg <= skid_vld_reg ? skid_data_reg : x7_reg;
        else if (!skid_vld_reg)
            skid_data_reg <= x7_reg;
    end

    assign result.valid = out_vld_reg;
    assign result.data  = out_data_reg;

    assign x1_active = pipe_vld_reg[cpcr_pkg::X1_IDX] && x1_reg.contact && !x1_reg.coinc;

    `CPCR_ASSERT_NEVER(a_skid_without_out, skid_vld_reg && !out_vld_reg, "skid full with output empty")
    `CPCR_ASSERT(a_skid_fill_on_stall, $rose(skid_vld_reg) |-> $past(out_vld_reg && !result.ready), "skid filled without stall")
    `CPCR_ASSERT(a_overlap_positive, x1_active |-> (x1_reg.ovl > 0), "non-positive overlap in contact")

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for circle_pair_collision_resolve: directed pairs, then random phases.
// Each accepted request is predicted in-bench or echoed (typed rows) and checked per field.
// Depends on cpcr_pkg, cpcr_pair_if, cpcr_result_if and the resolver RTL.
module tb_top;
    import cpcr_pkg::*;

    localparam int LATENCY = 48;
    localparam int DRAIN_CYCLES = LATENCY + 16;
    localparam int HOLDOFF_CYCLES = 400;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [REST_W-1:0] cfg_wdata;

    cpcr_pair_if   pair_ch();
    cpcr_result_if res_ch();

    circle_pair_collision_resolve dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .pair     (pair_ch),
        .result   (res_ch)
    );

    result_t      pending_results[$];
    logic [16:0]  rest_coef;
    int           errors;
    bit           no_gaps;
    bit           holdoff_go;
    bit           holdoff_on;

    pair_t        dir_pairs[$];
    bit           dir_typed[$];
    logic [1:0]   dir_status[$];

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ---------------- predictor ----------------
    function automatic longint round_shift(longint v, int s);
        longint half;
        half = longint'(1) <<< (s - 1);
        if (v >= 0)
            return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic longint round_div(longint num, longint den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= root + probe)
            begin
                v = v - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp24(longint v);
        if (v > 8388607)
            return 24'sh7FFFFF;
        if (v < -8388608)
            return 24'sh800000;
        return v[VAL_W-1:0];
    endfunction

    function automatic result_t resolve_pair(pair_t p, logic [16:0] rest);
        longint pax, pay, pbx, pby, vax, vay, vbx, vby;
        longint dx, dy, mind, d2, cdist, overlap, nx, ny, cx, cy, vn, k, imp, ix, iy;
        logic [1:0] status;
        result_t r;
        pax = p.pos_a_x; pay = p.pos_a_y; pbx = p.pos_b_x; pby = p.pos_b_y;
        vax = p.vel_a_x; vay = p.vel_a_y; vbx = p.vel_b_x; vby = p.vel_b_y;
        dx = pbx - pax;
        dy = pby - pay;
        mind = longint'(p.radius_a) + longint'(p.radius_b);
        d2 = dx * dx + dy * dy;
        status = ST_NONE;
        if (d2 < mind * mind)
        begin
            if (d2 == 0)
                status = ST_COINC;
            else
            begin
                cdist = longint'(int_sqrt(d2));
                overlap = mind - cdist;
                nx = round_div(dx * 65536, cdist);
                ny = round_div(dy * 65536, cdist);
                if (nx > 65536) nx = 65536;
                if (nx < -65536) nx = -65536;
                if (ny > 65536) ny = 65536;
                if (ny < -65536) ny = -65536;
                cx = round_shift(nx * overlap, 17);
                cy = round_shift(ny * overlap, 17);
                pax -= cx; pay -= cy;
                pbx += cx; pby += cy;
                vn = (vbx - vax) * nx + (vby - vay) * ny;
                if (vn > 0)
                    status = ST_SEP;
                else
                begin
                    k = 65536 + ((rest > 65536) ? 65536 : longint'(rest));
                    imp = round_shift(-vn * k, 33);
                    ix = round_shift(nx * imp, 16);
                    iy = round_shift(ny * imp, 16);
                    vax -= ix; vay -= iy;
                    vbx += ix; vby += iy;
                    status = ST_IMPULSE;
                end
            end
        end
        r.new_pos_a_x = clamp24(pax);
        r.new_pos_a_y = clamp24(pay);
        r.new_pos_b_x = clamp24(pbx);
        r.new_pos_b_y = clamp24(pby);
        r.new_vel_a_x = clamp24(vax);
        r.new_vel_a_y = clamp24(vay);
        r.new_vel_b_x = clamp24(vbx);
        r.new_vel_b_y = clamp24(vby);
        r.contact_status = status;
        return r;
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic check_result(result_t got, result_t want);
        if (got.new_pos_a_x !== want.new_pos_a_x)
            report_mismatch("new_pos_a_x", got.new_pos_a_x, want.new_pos_a_x);
        if (got.new_pos_a_y !== want.new_pos_a_y)
            report_mismatch("new_pos_a_y", got.new_pos_a_y, want.new_pos_a_y);
        if (got.new_pos_b_x !== want.new_pos_b_x)
            report_mismatch("new_pos_b_x", got.new_pos_b_x, want.new_pos_b_x);
        if (got.new_pos_b_y !== want.new_pos_b_y)
            report_mismatch("new_pos_b_y", got.new_pos_b_y, want.new_pos_b_y);
        if (got.new_vel_a_x !== want.new_vel_a_x)
            report_mismatch("new_vel_a_x", got.new_vel_a_x, want.new_vel_a_x);
        if (got.new_vel_a_y !== want.new_vel_a_y)
            report_mismatch("new_vel_a_y", got.new_vel_a_y, want.new_vel_a_y);
        if (got.new_vel_b_x !== want.new_vel_b_x)
            report_mismatch("new_vel_b_x", got.new_vel_b_x, want.new_vel_b_x);
        if (got.new_vel_b_y !== want.new_vel_b_y)
            report_mismatch("new_vel_b_y", got.new_vel_b_y, want.new_vel_b_y);
        if (got.contact_status !== want.contact_status)
            report_mismatch("contact_status", got.contact_status, want.contact_status);
    endtask

    // Result side: check the pre-edge handshake, then pick ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                errors++;
            end
            else
                check_result(res_ch.data, pending_results.pop_front());
        end
        if (holdoff_on)
            res_ch.ready <= 1'b0;
        else if (no_gaps)
            res_ch.ready <= 1'b1;
        else
            res_ch.ready <= ($urandom_range(99) >= 25);
    end

    // Long receiver hold-off, counted here while the sender keeps offering
    initial
    begin
        holdoff_on = 1'b0;
        wait (holdoff_go);
        @(posedge clk);
        holdoff_on = 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff_on = 1'b0;
    end

    // ---------------- stimulus ----------------
    task automatic send_pair(pair_t p, bit typed, logic [1:0] status);
        result_t want;
        while (!no_gaps && $urandom_range(99) < 25)
        begin
            pair_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pair_ch.valid <= 1'b1;
        pair_ch.data  <= p;
        // ready only moves at the rising edge, so sample it mid-cycle
        @(negedge clk);
        while (!pair_ch.ready)
            @(negedge clk);
        @(posedge clk);
        if (typed)
        begin
            want.new_pos_a_x = p.pos_a_x; want.new_pos_a_y = p.pos_a_y;
            want.new_pos_b_x = p.pos_b_x; want.new_pos_b_y = p.pos_b_y;
            want.new_vel_a_x = p.vel_a_x; want.new_vel_a_y = p.vel_a_y;
            want.new_vel_b_x = p.vel_b_x; want.new_vel_b_y = p.vel_b_y;
            want.contact_status = status;
        end
        else
            want = resolve_pair(p, rest_coef);
        pending_results.push_back(want);
    endtask

    task automatic write_restitution(logic [REST_W-1:0] v);
        pair_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        rest_coef = v;
    endtask

    function automatic pair_t mk_pair(int ax, int ay, int bx, int by,
                                      int vax, int vay, int vbx, int vby,
                                      int ra, int rb);
        pair_t p;
        p.pos_a_x = ax[23:0]; p.pos_a_y = ay[23:0];
        p.pos_b_x = bx[23:0]; p.pos_b_y = by[23:0];
        p.vel_a_x = vax[23:0]; p.vel_a_y = vay[23:0];
        p.vel_b_x = vbx[23:0]; p.vel_b_y = vby[23:0];
        p.radius_a = ra[19:0]; p.radius_b = rb[19:0];
        return p;
    endfunction

    task automatic add_row(pair_t p, bit typed, logic [1:0] status);
        dir_pairs.push_back(p);
        dir_typed.push_back(typed);
        dir_status.push_back(status);
    endtask

    function automatic logic [23:0] rand_val(int bits);
        int v;
        v = $urandom_range(0, (1 << bits) - 1);
        if ($urandom_range(1))
            v = -v;
        return v[23:0];
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int mode, rbits, span, dx, dy;
        mode = $urandom_range(99);
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             8'($urandom)};
        if (mode < 65)
        begin
            // near contact: each axis offset of the centres lies within the radius sum
            rbits = $urandom_range(2, 20);
            p.radius_a = 20'($urandom_range(0, (1 << rbits) - 1));
            p.radius_b = 20'($urandom_range(0, (1 << rbits) - 1));
            span = int'(p.radius_a) + int'(p.radius_b);
            dx = int'($urandom_range(0, 2 * span)) - span;
            dy = int'($urandom_range(0, 2 * span)) - span;
            if (mode < 8)
            begin
                dx = 0;
                dy = 0;
            end
            p.pos_a_x = rand_val($urandom_range(4, 23));
            p.pos_a_y = rand_val($urandom_range(4, 23));
            p.pos_b_x = p.pos_a_x + dx[23:0];
            p.pos_b_y = p.pos_a_y + dy[23:0];
            rbits = $urandom_range(2, 23);
            p.vel_a_x = rand_val(rbits);
            p.vel_a_y = rand_val(rbits);
            p.vel_b_x = rand_val(rbits);
            p.vel_b_y = rand_val(rbits);
        end
        else if (mode < 80)
        begin
            // near the rails, so saturation is exercised
            p.pos_a_x = $urandom_range(1) ? 24'h7FFFF0 : 24'h800010;
            p.pos_b_x = p.pos_a_x + rand_val(6);
            p.radius_a = 20'($urandom_range(0, 1048575));
        end
        return p;
    endfunction

    task automatic random_phase(int count);
        repeat (count)
            send_pair(random_pair(), 1'b0, ST_NONE);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        pair_ch.valid = 1'b0;
        pair_ch.data = '0;
        res_ch.ready = 1'b0;
        errors = 0;
        no_gaps = 1'b0;
        holdoff_go = 1'b0;
        rest_coef = REST_RESET;

        // echoed rows carry their status; the rest go through the predictor
        add_row(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, ST_NONE);
        add_row(mk_pair(0, 0, 100000, 0, 5, 6, 7, 8, 256, 256), 1'b1, ST_NONE);
        add_row(mk_pair(1234, -77, 1234, -77, 300, -300, 9, 9, 10, 0), 1'b1, ST_COINC);
        add_row(mk_pair(8388607, 8388607, -8388608, -8388608,
                        8388607, -8388608, -8388608, 8388607, 0, 0), 1'b1, ST_NONE);
        add_row(mk_pair(-8388608, 8388607, -8388608, 8388607,
                        8388607, 8388607, -8388608, -8388608, 1048575, 1048575),
                1'b1, ST_COINC);
        add_row(mk_pair(0, 0, 768, 0, 256, 0, -256, 0, 512, 512), 1'b0, ST_NONE);
        add_row(mk_pair(0, 0, 768, 0, -256, 0, 256, 0, 512, 512), 1'b0, ST_NONE);
        add_row(mk_pair(0, 0, 768, 0, 40, 40, 40, 40, 512, 512), 1'b0, ST_NONE);
        add_row(mk_pair(0, 0, 300, 400, 8388607, 8388607, -8388608, -8388608,
                        400, 400), 1'b0, ST_NONE);
        add_row(mk_pair(8388000, 8388000, 8388300, 8388300, 0, 0, 0, 0,
                        1048575, 1048575), 1'b0, ST_NONE);
        add_row(mk_pair(-8388608, -8388608, -8388000, -8388000, 100, 0, -100, 0,
                        1048575, 1048575), 1'b0, ST_NONE);
        add_row(mk_pair(0, 0, 1, 0, 0, 0, 0, 0, 1048575, 1048575), 1'b0, ST_NONE);
        add_row(mk_pair(0, 0, 0, -1, 0, 5, 0, -5, 1, 0), 1'b0, ST_NONE);
        add_row(mk_pair(-500, 200, 500, -200, 1000, -3000, -2000, 70, 700, 700),
                1'b0, ST_NONE);
        add_row(mk_pair(0, 0, 8388607, 0, 0, 0, 0, 0, 1048575, 1048575), 1'b0, ST_NONE);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_pairs[i])
            send_pair(dir_pairs[i], dir_typed[i], dir_status[i]);
        random_phase(300);

        write_restitution(17'd0);
        random_phase(300);

        write_restitution(REST_ONE);
        no_gaps = 1'b1;
        random_phase(250);
        no_gaps = 1'b0;

        // saturated coefficient, with the receiver held off to fill the pipe
        write_restitution(17'd131071);
        holdoff_go = 1'b1;
        no_gaps = 1'b1;
        random_phase(300);
        no_gaps = 1'b0;

        write_restitution(17'($urandom_range(0, 131071)));
        random_phase(300);

        write_restitution(REST_RESET);
        random_phase(330);

        pair_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/cpcr_pkg.sv
hdl/cpcr_pair_if.sv
hdl/cpcr_result_if.sv
hdl/cpcr_sqrt.sv
hdl/cpcr_div.sv
hdl/circle_pair_collision_resolve.sv
tb/sv/tb_top.sv
